@@ hw/rtl/kotab_pkg.sv @@
// ----------------------------------------------------------------------------
// kotab_pkg: shared constants for the keyed override max table
// Field widths of the request and response items and the request type codes.
// ----------------------------------------------------------------------------
package kotab_pkg;

   // Field widths of the request item
   localparam int unsigned REQ_TYPE_W  = 1;
   localparam int unsigned REASON_ID_W = 16;
   localparam int unsigned LEVEL_W     = 2;

   // Field widths of the response item
   localparam int unsigned ENTRY_COUNT_W = 4;

   // Request type codes
   localparam logic [REQ_TYPE_W-1:0] REQ_SET_CLEAR = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY     = 1'b1;

endpackage

@@ hw/rtl/kotab_req_if.sv @@
// ----------------------------------------------------------------------------
// kotab_req_if: request channel of the keyed override max table
// Valid/ready handshake carrying one set, clear or query request.
// ----------------------------------------------------------------------------
interface kotab_req_if;

   logic                                  valid;
   logic                                  ready;
   logic [kotab_pkg::REQ_TYPE_W-1:0]      req_type;
   logic [kotab_pkg::REASON_ID_W-1:0]     reason_id;
   logic                                  level_present;
   logic [kotab_pkg::LEVEL_W-1:0]         level_value;

   modport source (
      output valid,
      output req_type,
      output reason_id,
      output level_present,
      output level_value,
      input  ready
   );

   modport sink (
      input  valid,
      input  req_type,
      input  reason_id,
      input  level_present,
      input  level_value,
      output ready
   );

endinterface

@@ hw/rtl/kotab_rsp_if.sv @@
// ----------------------------------------------------------------------------
// kotab_rsp_if: response channel of the keyed override max table
// Valid/ready handshake carrying the effective level and table status.
// ----------------------------------------------------------------------------
interface kotab_rsp_if;

   logic                                  valid;
   logic                                  ready;
   logic [kotab_pkg::LEVEL_W-1:0]         effective_level;
   logic                                  reason_found;
   logic                                  table_full;
   logic [kotab_pkg::ENTRY_COUNT_W-1:0]   entry_count;

   modport source (
      output valid,
      output effective_level,
      output reason_found,
      output table_full,
      output entry_count,
      input  ready
   );

   modport sink (
      input  valid,
      input  effective_level,
      input  reason_found,
      input  table_full,
      input  entry_count,
      output ready
   );

endinterface

@@ hw/rtl/keyed_override_max_table.sv @@
// ----------------------------------------------------------------------------
// keyed_override_max_table: override table with max level reduction
// Looks up a reason key, overwrites, appends or removes its entry, and reports
// the maximum level over all entries (base level when the table is empty).
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          contents
//   req      in         valid/ready        req_type, reason_id, level_present,
//                                          level_value
//   rsp      out        valid/ready        effective_level, reason_found,
//                                          table_full, entry_count
//   csr      in         csr_wr_en          csr_wr_data = base level
//
// A request runs from acceptance to the next acceptance through the sequencer
// states in order: it scans the N entries in use through the entry RAM's
// single read port, one entry per cycle, drains the registered read, then
// writes the entry, loads the response register and returns to idle.
// req.ready is high only while the sequencer is idle; a response waiting on
// rsp.ready does not hold off the next request, which stalls in the load step
// until the response register frees.
// Reset empties the table at once and sets the base level to 1; no clearing
// pass runs.
// ----------------------------------------------------------------------------
module keyed_override_max_table #(
   parameter int unsigned TABLE_ENTRIES = 8,
   parameter int unsigned REASON_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   kotab_req_if.sink                      req,
   kotab_rsp_if.source                    rsp,
   input  logic                           csr_wr_en,
   input  logic [kotab_pkg::LEVEL_W-1:0]  csr_wr_data
);

   localparam int unsigned KEY_W = (REASON_BITS < kotab_pkg::REASON_ID_W) ?
                                   REASON_BITS : kotab_pkg::REASON_ID_W;
   localparam int unsigned ENT_W = KEY_W + kotab_pkg::LEVEL_W;
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
   localparam int unsigned ENTRY_PAD = kotab_pkg::ENTRY_COUNT_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   localparam int unsigned LW = kotab_pkg::LEVEL_W;

   // Control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [LW-1:0]     base_level_ff, base_level_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Scan bookkeeping
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [LW-1:0]     found_lvl_ff, found_lvl_in;
   logic [LW-1:0]     max_ff, max_in;
   logic [ENT_W-1:0]  last_ff, last_in;

   // Latched request
   logic              req_type_ff, req_type_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              lvl_present_ff, lvl_present_in;
   logic [LW-1:0]     lvl_ff, lvl_in;

   // Staged result and response register
   logic [LW-1:0]     res_eff_ff, res_eff_in;
   logic              res_found_ff, res_found_in;
   logic              res_full_ff, res_full_in;
   logic [LW-1:0]     rsp_eff_ff, rsp_eff_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_full_ff, rsp_full_in;
   logic [CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // RAM port signals
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ENT_W-1:0]  ram_rd_data;

   // Decode helpers
   logic              req_accept;
   logic              issue;
   logic [KEY_W-1:0]  rd_key;
   logic [LW-1:0]     rd_lvl;
   logic              is_update;
   logic              do_overwrite;
   logic              do_remove;
   logic              do_append;
   logic              do_drop;
   logic [CNT_W-1:0]  used_after;
   logic [LW-1:0]     max_with_new;
   logic [LW-1:0]     max_with_found;
   logic [CNT_W+ENTRY_PAD-1:0] cnt_ext;

   kotab_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;

   // Issue one read per cycle while unscanned entries remain
   assign issue       = (state_ff == ST_SCAN) && (iss_ff < used_ff);
   assign ram_rd_en   = issue;
   assign ram_rd_addr = iss_ff[IDX_W-1:0];
   assign rd_key      = ram_rd_data[ENT_W-1:LW];
   assign rd_lvl      = ram_rd_data[LW-1:0];

   // Classify the update once the scan is complete
   assign is_update    = (req_type_ff == kotab_pkg::REQ_SET_CLEAR);
   assign do_overwrite = is_update && found_ff && lvl_present_ff;
   assign do_remove    = is_update && found_ff && !lvl_present_ff;
   assign do_append    = is_update && !found_ff && lvl_present_ff && (used_ff < CNT_FULL);
   assign do_drop      = is_update && !found_ff && lvl_present_ff && (used_ff >= CNT_FULL);

   assign ram_wr_en   = (state_ff == ST_WRITE) && (do_overwrite || do_remove || do_append);
   assign ram_wr_addr = do_append ? used_ff[IDX_W-1:0] : slot_ff;
   assign ram_wr_data = do_remove ? last_ff : {key_ff, lvl_ff};

   assign max_with_new   = (lvl_ff > max_ff) ? lvl_ff : max_ff;
   assign max_with_found = (found_ff && (found_lvl_ff > max_ff)) ? found_lvl_ff : max_ff;

   always_comb begin
      used_after = used_ff;
      if (do_append) begin
         used_after = used_ff + 1'b1;
      end else if (do_remove) begin
         used_after = used_ff - 1'b1;
      end
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      base_level_in  = base_level_ff;
      rsp_valid_in   = rsp_valid_ff;
      iss_in         = iss_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      found_in       = found_ff;
      slot_in        = slot_ff;
      found_lvl_in   = found_lvl_ff;
      max_in         = max_ff;
      last_in        = last_ff;
      req_type_in    = req_type_ff;
      key_in         = key_ff;
      lvl_present_in = lvl_present_ff;
      lvl_in         = lvl_ff;
      res_eff_in     = res_eff_ff;
      res_found_in   = res_found_ff;
      res_full_in    = res_full_ff;
      rsp_eff_in     = rsp_eff_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_cnt_in     = rsp_cnt_ff;

      // Take a base level write
      if (csr_wr_en) begin
         base_level_in = csr_wr_data;
      end

      // Drop the response once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_type_in    = req.req_type;
               key_in         = req.reason_id[KEY_W-1:0];
               lvl_present_in = req.level_present;
               lvl_in         = req.level_value;
               iss_in         = '0;
               pend_in        = 1'b0;
               found_in       = 1'b0;
               slot_in        = '0;
               found_lvl_in   = '0;
               max_in         = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Advance the read pointer
            pend_in     = issue;
            pend_idx_in = iss_ff[IDX_W-1:0];
            if (issue) begin
               iss_in = iss_ff + 1'b1;
            end
            // Consume the entry read in the previous cycle
            if (pend_ff) begin
               if ((rd_key == key_ff) && !found_ff) begin
                  found_in     = 1'b1;
                  slot_in      = pend_idx_ff;
                  found_lvl_in = rd_lvl;
               end else if (rd_lvl > max_ff) begin
                  max_in = rd_lvl;
               end
               if ((CNT_W'(pend_idx_ff) + 1'b1) == used_ff) begin
                  last_in = ram_rd_data;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            used_in      = used_after;
            res_found_in = found_ff;
            res_full_in  = do_drop;
            if (used_after == '0) begin
               res_eff_in = base_level_ff;
            end else if (do_overwrite || do_append) begin
               res_eff_in = max_with_new;
            end else if (do_remove) begin
               res_eff_in = max_ff;
            end else begin
               res_eff_in = max_with_found;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Load the response register once it is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_eff_in   = res_eff_ff;
               rsp_found_in = res_found_ff;
               rsp_full_in  = res_full_ff;
               rsp_cnt_in   = used_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         base_level_ff <= LW'(1);
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         base_level_ff <= base_level_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      iss_ff         <= iss_in;
      pend_idx_ff    <= pend_idx_in;
      found_ff       <= found_in;
      slot_ff        <= slot_in;
      found_lvl_ff   <= found_lvl_in;
      max_ff         <= max_in;
      last_ff        <= last_in;
      req_type_ff    <= req_type_in;
      key_ff         <= key_in;
      lvl_present_ff <= lvl_present_in;
      lvl_ff         <= lvl_in;
      res_eff_ff     <= res_eff_in;
      res_found_ff   <= res_found_in;
      res_full_ff    <= res_full_in;
      rsp_eff_ff     <= rsp_eff_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

   // Drive the response channel; entry_count is the low bits of the count
   assign cnt_ext             = {{ENTRY_PAD{1'b0}}, rsp_cnt_ff};
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.effective_level = rsp_eff_ff;
   assign rsp.reason_found    = rsp_found_ff;
   assign rsp.table_full      = rsp_full_ff;
   assign rsp.entry_count     = cnt_ext[kotab_pkg::ENTRY_COUNT_W-1:0];

`ifndef SYNTH
   // The entry count never exceeds the table size
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_FULL)
      else $error("entry count above table size");

   // An accepted request always starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   // A dropped append only happens on a full table, which stays full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (rsp_cnt_ff == CNT_FULL))
      else $error("table_full reported on a table that is not full");

   // A found reason is never reported as a dropped append
   a_found_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_full_ff))
      else $error("reason_found and table_full both set");

   // The count changes only in the write step, so at most once per request
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_WRITE) |=> (used_ff == $past(used_ff)))
      else $error("entry count changed outside the write step");
`endif

endmodule

@@ hw/rtl/kotab_ram.sv @@
// ----------------------------------------------------------------------------
// kotab_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kotab_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/tb_keyed_override_max_table.sv @@
// ----------------------------------------------------------------------------
// tb_keyed_override_max_table: self-checking bench for the override max table
// Sends set, clear and query requests through the request channel. A shadow
// copy of the table predicts every response, and a monitor compares each
// response against the oldest prediction. Directed corner cases come first,
// then random request bursts under several idle and stall patterns and
// base level settings.
// ----------------------------------------------------------------------------
module tb_keyed_override_max_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_ENTRIES = 8;
   localparam int unsigned REASON_BITS   = 16;
   localparam int unsigned POOL_SIZE     = 10;
   localparam int unsigned PHASE_ITEMS   = 500;
   localparam int unsigned BURST_LEN     = 40;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned MAX_REPORTS   = 10;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [kotab_pkg::REQ_TYPE_W-1:0]  req_type;
      logic [kotab_pkg::REASON_ID_W-1:0] reason_id;
      logic                              level_present;
      logic [kotab_pkg::LEVEL_W-1:0]     level_value;
   } override_req_type;

   typedef struct packed {
      logic [kotab_pkg::LEVEL_W-1:0]       effective_level;
      logic                                reason_found;
      logic                                table_full;
      logic [kotab_pkg::ENTRY_COUNT_W-1:0] entry_count;
   } override_rsp_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [kotab_pkg::LEVEL_W-1:0] csr_wr_data;

   kotab_req_if req_bus ();
   kotab_rsp_if rsp_bus ();

   keyed_override_max_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .REASON_BITS   (REASON_BITS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Requests waiting to be sent and responses still owed by the block
   override_req_type pending_reqs [$];
   override_rsp_type owed_rsps [$];
   override_req_type driven_req;

   // Shadow copy of the override table
   logic [kotab_pkg::REASON_ID_W-1:0] shadow_reason [TABLE_ENTRIES];
   logic [kotab_pkg::LEVEL_W-1:0]     shadow_level [TABLE_ENTRIES];
   int unsigned                       shadow_used;
   logic [kotab_pkg::LEVEL_W-1:0]     shadow_base;

   idle_mode_type                     idle_mode;
   int unsigned                       mismatch_count;
   logic [kotab_pkg::REASON_ID_W-1:0] key_pool [POOL_SIZE];

   // Apply one request to the shadow table and return the response it yields
   function automatic override_rsp_type apply_override(input override_req_type r);
      bit                            found;
      bit                            dropped;
      int unsigned                   slot;
      logic [kotab_pkg::LEVEL_W-1:0] top;
      override_rsp_type              res;
      found   = 1'b0;
      dropped = 1'b0;
      slot    = 0;
      for (int unsigned i = 0; i < shadow_used; i++) begin
         if (!found && shadow_reason[i] == r.reason_id) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (r.req_type == kotab_pkg::REQ_SET_CLEAR) begin
         if (found) begin
            if (r.level_present) begin
               shadow_level[slot] = r.level_value;
            end else begin
               // move the last entry into the freed slot
               shadow_reason[slot] = shadow_reason[shadow_used - 1];
               shadow_level[slot]  = shadow_level[shadow_used - 1];
               shadow_used--;
            end
         end else if (r.level_present) begin
            if (shadow_used < TABLE_ENTRIES) begin
               shadow_reason[shadow_used] = r.reason_id;
               shadow_level[shadow_used]  = r.level_value;
               shadow_used++;
            end else begin
               dropped = 1'b1;
            end
         end
      end
      top = '0;
      for (int unsigned i = 0; i < shadow_used; i++) begin
         if (shadow_level[i] > top) begin
            top = shadow_level[i];
         end
      end
      res.effective_level = (shadow_used == 0) ? shadow_base : top;
      res.reason_found    = found;
      res.table_full      = dropped;
      res.entry_count     = shadow_used[kotab_pkg::ENTRY_COUNT_W-1:0];
      return res;
   endfunction

   // Decide whether a side idles this cycle under the current pattern
   function automatic bit idles_now(input bit sender);
      int unsigned pct;
      pct = 0;
      if (idle_mode == IDLE_BOTH) begin
         pct = 10;
      end else if (sender && idle_mode == IDLE_SENDER) begin
         pct = 49;
      end else if (!sender && idle_mode == IDLE_RECEIVER) begin
         pct = 49;
      end
      return $urandom_range(99) < pct;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #2_000_000;
      $display("tb_keyed_override_max_table: done, errors");
      $finish;
   end

   // Request driver: predict on acceptance, then present the next request
   always @(posedge clock) begin : request_driver
      override_req_type next_req;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            owed_rsps.insert(owed_rsps.size(), apply_override(driven_req));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_reqs.size() != 0 && !idles_now(1'b1)) begin
               next_req = pending_reqs.pop_front();
               driven_req            <= next_req;
               req_bus.req_type      <= next_req.req_type;
               req_bus.reason_id     <= next_req.reason_id;
               req_bus.level_present <= next_req.level_present;
               req_bus.level_value   <= next_req.level_value;
               req_bus.valid         <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver: stall at random
   always @(posedge clock) begin : response_receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !idles_now(1'b0);
      end
   end

   // Response monitor: check each response against the oldest prediction
   always @(posedge clock) begin : response_monitor
      override_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("response with none pending: level=%0d found=%0d %s",
                        rsp_bus.effective_level, rsp_bus.reason_found,
                        $sformatf("full=%0d count=%0d",
                                  rsp_bus.table_full, rsp_bus.entry_count));
            end
         end else begin
            want = owed_rsps.pop_front();
            if (rsp_bus.effective_level !== want.effective_level ||
                rsp_bus.reason_found !== want.reason_found ||
                rsp_bus.table_full !== want.table_full ||
                rsp_bus.entry_count !== want.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("mismatch at %0t: expected level=%0d found=%0d %s",
                           $realtime, want.effective_level, want.reason_found,
                           $sformatf("full=%0d count=%0d, got level=%0d %s",
                                     want.table_full, want.entry_count,
                                     rsp_bus.effective_level,
                                     $sformatf("found=%0d full=%0d count=%0d",
                                               rsp_bus.reason_found,
                                               rsp_bus.table_full,
                                               rsp_bus.entry_count)));
               end
            end
         end
      end
   end

   // Queue one request
   task automatic push_req(input logic [kotab_pkg::REQ_TYPE_W-1:0] kind,
                           input logic [kotab_pkg::REASON_ID_W-1:0] reason,
                           input logic present,
                           input logic [kotab_pkg::LEVEL_W-1:0] lvl);
      override_req_type r;
      r.req_type      = kind;
      r.reason_id     = reason;
      r.level_present = present;
      r.level_value   = lvl;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // Hold until every request is sent and every response has come back
   task automatic drain();
      while (pending_reqs.size() != 0 || req_bus.valid || owed_rsps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write the base level register; only called with the block idle
   task automatic write_base(input logic [kotab_pkg::LEVEL_W-1:0] lvl);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lvl;
      shadow_base = lvl;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Queue random requests in bursts, each chosen at random to lean to fill or drain
   task automatic queue_random(input int unsigned count);
      int unsigned                       roll;
      int unsigned                       set_pct;
      logic [kotab_pkg::REASON_ID_W-1:0] key;
      set_pct = 65;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % BURST_LEN == 0) begin
            set_pct = $urandom_range(1) ? 65 : 20;
         end
         roll = $urandom_range(99);
         key  = key_pool[$urandom_range(POOL_SIZE - 1)];
         if (roll < set_pct) begin
            push_req(kotab_pkg::REQ_SET_CLEAR, key, 1'b1, 2'($urandom_range(3)));
         end else if (roll < 85) begin
            push_req(kotab_pkg::REQ_SET_CLEAR, key, 1'b0, 2'($urandom_range(3)));
         end else if (roll < 95) begin
            push_req(kotab_pkg::REQ_QUERY, key, 1'($urandom_range(1)),
                     2'($urandom_range(3)));
         end else begin
            push_req(1'($urandom_range(1)), 16'($urandom_range(16'hFFFF)),
                     1'($urandom_range(1)), 2'($urandom_range(3)));
         end
      end
   endtask

   // One random phase with a full pause halfway through
   task automatic run_phase(input idle_mode_type mode,
                            input logic [kotab_pkg::LEVEL_W-1:0] base);
      write_base(base);
      idle_mode = mode;
      for (int unsigned k = 0; k < POOL_SIZE; k++) begin
         key_pool[k] = 16'($urandom_range(16'hFFFF));
      end
      queue_random(PHASE_ITEMS / 2);
      drain();
      queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      drain();
   endtask

   // Stimulus and end of run
   initial begin
      logic [kotab_pkg::REASON_ID_W-1:0] leftovers [5];
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_bus.valid         = 1'b0;
      req_bus.req_type      = kotab_pkg::REQ_SET_CLEAR;
      req_bus.reason_id     = '0;
      req_bus.level_present = 1'b0;
      req_bus.level_value   = '0;
      rsp_bus.ready         = 1'b0;
      driven_req            = '0;
      shadow_used           = 0;
      shadow_base           = 2'd1;
      idle_mode             = IDLE_NONE;
      mismatch_count        = 0;
      leftovers             = '{16'hFFFF, 16'hAAAA, 16'h0001, 16'h8000, 16'h00FF};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // query and clear on an empty table report the reset base level
      push_req(kotab_pkg::REQ_QUERY, 16'h0000, 1'b0, 2'd0);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h1234, 1'b0, 2'd3);
      // append at the key extremes, then overwrite
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h0000, 1'b1, 2'd0);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'hFFFF, 1'b1, 2'd3);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'hFFFF, 1'b1, 2'd2);
      // query ignores level fields
      push_req(kotab_pkg::REQ_QUERY, 16'hFFFF, 1'b1, 2'd3);
      // fill the table
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h5555, 1'b1, 2'd1);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'hAAAA, 1'b1, 2'd3);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h0001, 1'b1, 2'd1);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h8000, 1'b1, 2'd0);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h00FF, 1'b1, 2'd1);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'hFF00, 1'b1, 2'd2);
      // append to a full table is dropped; overwrite still works
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h1357, 1'b1, 2'd3);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'hAAAA, 1'b1, 2'd0);
      // remove from the middle, the moved last entry, and the first
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h5555, 1'b0, 2'd0);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'hFF00, 1'b0, 2'd0);
      push_req(kotab_pkg::REQ_SET_CLEAR, 16'h0000, 1'b0, 2'd0);
      push_req(kotab_pkg::REQ_QUERY, 16'hFF00, 1'b0, 2'd0);
      // empty the table again
      foreach (leftovers[k]) begin
         push_req(kotab_pkg::REQ_SET_CLEAR, leftovers[k], 1'b0, 2'd0);
      end
      drain();

      run_phase(IDLE_NONE, 2'd3);
      run_phase(IDLE_SENDER, 2'd0);
      run_phase(IDLE_RECEIVER, 2'd2);
      run_phase(IDLE_BOTH, 2'd1);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && owed_rsps.size() == 0) begin
         $display("tb_keyed_override_max_table: done, clean");
      end else begin
         $display("tb_keyed_override_max_table: done, errors");
      end
      $finish;
   end

endmodule

@@ keyed_override_max_table.f @@
hw/rtl/kotab_pkg.sv
hw/rtl/kotab_req_if.sv
hw/rtl/kotab_rsp_if.sv
hw/rtl/kotab_ram.sv
hw/rtl/keyed_override_max_table.sv
tb/tb_keyed_override_max_table.sv
